// ----- src/l2pc_pkg.sv -----
package l2pc_pkg;

  // Field and register widths
  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;
  localparam int IN_W        = 32;
  localparam int TRIG_W      = 16;
  localparam int TRIG_FRAC   = 14;
  localparam int LIM_W       = 31;
  localparam int ADDR_W      = 4;
  localparam int IDX_W       = ADDR_W - 2;

  // Datapath widths
  localparam int PROD_W = IN_W + TRIG_W;       // trig by coordinate product
  localparam int SUM_W  = PROD_W + 1;          // sum of two products
  localparam int UD_W   = PROD_W;              // magnitude of such a sum
  localparam int NUM_W  = UD_W + FRAC_BITS;    // scaled dividend
  localparam int QW     = LIM_W;               // quotient bits kept
  localparam int A_W    = SUM_W - TRIG_FRAC;   // rotated coordinate, coord scale
  localparam int TM_W   = UD_W;                // magnitude of t
  localparam int TH_W   = TM_W / 2;            // low slice of t for the split multiply
  localparam int SH     = FRAC_BITS + TRIG_FRAC;
  localparam int PM_W   = QW + TM_W;           // full slope by t product
  localparam int SP_W   = PM_W - SH + 1;       // scaled signed product
  localparam int U_W    = SP_W + 1;            // intercept before saturation
  localparam int V_W    = QW + 1;              // signed slope

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_PARALLEL  = 2'd1;
  localparam logic [1:0] ST_TRANS_OUT = 2'd2;
  localparam logic [1:0] ST_AXIAL_OUT = 2'd3;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_COS       = 2'd0;
  localparam logic [IDX_W-1:0] REG_SIN       = 2'd1;
  localparam logic [IDX_W-1:0] REG_MAX_TRANS = 2'd2;
  localparam logic [IDX_W-1:0] REG_MAX_AXIAL = 2'd3;

  // Reset values
  localparam logic [TRIG_W-1:0] COS_RST       = 16'd16384;
  localparam logic [TRIG_W-1:0] SIN_RST       = 16'd0;
  localparam logic [LIM_W-1:0]  MAX_TRANS_RST = 31'd65536;
  localparam logic [LIM_W-1:0]  MAX_AXIAL_RST = 31'd0;

  // Token handed along the divider chain
  typedef struct packed {
    logic                    vld;
    logic                    par;
    logic                    c_neg;
    logic                    n0_neg;
    logic                    n1_neg;
    logic [UD_W-1:0]         ud;
    logic [UD_W-1:0]         r0;
    logic [UD_W-1:0]         r1;
    logic [QW-1:0]           lo0;
    logic [QW-1:0]           lo1;
    logic [QW-1:0]           q0;
    logic [QW-1:0]           q1;
    logic                    ovf0;
    logic                    ovf1;
    logic                    t_neg;
    logic [TM_W-1:0]         t_mag;
    logic signed [A_W-1:0]   a;
    logic signed [IN_W-1:0]  pz;
  } l2pc_tok_t;

  function automatic logic signed [COORD_WIDTH-1:0] sat_coord(input logic signed [U_W-1:0] v);
    logic signed [U_W-1:0] hi;
    logic signed [U_W-1:0] lo;
    hi = $signed({{(U_W-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}});
    lo = ~hi;
    if (v > hi) begin
      return {1'b0, {(COORD_WIDTH-1){1'b1}}};
    end else if (v < lo) begin
      return {1'b1, {(COORD_WIDTH-1){1'b0}}};
    end
    return v[COORD_WIDTH-1:0];
  endfunction

endpackage

// ----- src/l2pc_if.sv -----
interface l2pc_in_if import l2pc_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [IN_W-1:0] dir_x;
  logic signed [IN_W-1:0] dir_y;
  logic signed [IN_W-1:0] dir_z;
  logic signed [IN_W-1:0] pt_x;
  logic signed [IN_W-1:0] pt_y;
  logic signed [IN_W-1:0] pt_z;

  modport source (output valid, dir_x, dir_y, dir_z, pt_x, pt_y, pt_z, input ready);
  modport sink (input valid, dir_x, dir_y, dir_z, pt_x, pt_y, pt_z, output ready);
endinterface

interface l2pc_out_if import l2pc_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic [1:0]                    status;
  logic signed [COORD_WIDTH-1:0] slope_transaxial;
  logic signed [COORD_WIDTH-1:0] slope_axial;
  logic signed [COORD_WIDTH-1:0] icpt_transaxial;
  logic signed [COORD_WIDTH-1:0] icpt_axial;

  modport source (output valid, status, slope_transaxial, slope_axial, icpt_transaxial,
                  icpt_axial, input ready);
  modport sink (input valid, status, slope_transaxial, slope_axial, icpt_transaxial,
                icpt_axial, output ready);
endinterface

// ----- src/l2pc_front.sv -----
module l2pc_front import l2pc_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     vld_i,
  input  logic signed [IN_W-1:0]   dir_x_i,
  input  logic signed [IN_W-1:0]   dir_y_i,
  input  logic signed [IN_W-1:0]   dir_z_i,
  input  logic signed [IN_W-1:0]   pt_x_i,
  input  logic signed [IN_W-1:0]   pt_y_i,
  input  logic signed [IN_W-1:0]   pt_z_i,
  input  logic signed [TRIG_W-1:0] cos_i,
  input  logic signed [TRIG_W-1:0] sin_i,
  output l2pc_tok_t                tok_o
);

  // Stage 1: products
  logic                     vld1_q;
  logic signed [PROD_W-1:0] cry_q, srx_q, crx_q, sry_q, cpy_q, spx_q, cpx_q, spy_q;
  logic signed [IN_W-1:0]   rz1_q, pz1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
    end else if (en_i) begin
      vld1_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cry_q <= cos_i * dir_y_i;
      srx_q <= sin_i * dir_x_i;
      crx_q <= cos_i * dir_x_i;
      sry_q <= sin_i * dir_y_i;
      cpy_q <= cos_i * pt_y_i;
      spx_q <= sin_i * pt_x_i;
      cpx_q <= cos_i * pt_x_i;
      spy_q <= sin_i * pt_y_i;
      rz1_q <= dir_z_i;
      pz1_q <= pt_z_i;
    end
  end

  // Stage 2: sums, magnitudes and signs
  logic signed [SUM_W-1:0] c_w, n0s_w, t_w, a_w;
  logic [SUM_W-1:0]        cm_w, n0m_w, tm_w, am_w;
  logic [IN_W:0]           rzm_w;
  logic [A_W-1:0]          ash_w;

  assign c_w   = SUM_W'(cry_q) - SUM_W'(srx_q);
  assign n0s_w = SUM_W'(crx_q) + SUM_W'(sry_q);
  assign t_w   = SUM_W'(cpy_q) - SUM_W'(spx_q);
  assign a_w   = SUM_W'(cpx_q) + SUM_W'(spy_q);
  assign cm_w  = c_w[SUM_W-1] ? SUM_W'(-c_w) : SUM_W'(c_w);
  assign n0m_w = n0s_w[SUM_W-1] ? SUM_W'(-n0s_w) : SUM_W'(n0s_w);
  assign tm_w  = t_w[SUM_W-1] ? SUM_W'(-t_w) : SUM_W'(t_w);
  assign am_w  = a_w[SUM_W-1] ? SUM_W'(-a_w) : SUM_W'(a_w);
  assign rzm_w = rz1_q[IN_W-1] ? (IN_W+1)'(-(IN_W+1)'(rz1_q)) : (IN_W+1)'(rz1_q);
  assign ash_w = A_W'(am_w >> TRIG_FRAC);

  logic                   vld2_q;
  logic                   par2_q, c_neg2_q, n0_neg2_q, n1_neg2_q, t_neg2_q;
  logic [UD_W-1:0]        ud2_q, un0_q, un1_q;
  logic [TM_W-1:0]        tm2_q;
  logic signed [A_W-1:0]  a2_q;
  logic signed [IN_W-1:0] pz2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld2_q <= 1'b0;
    end else if (en_i) begin
      vld2_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      par2_q    <= (c_w == '0);
      c_neg2_q  <= c_w[SUM_W-1];
      ud2_q     <= cm_w[UD_W-1:0];
      // the dividends are negated sums: flip the sign
      n0_neg2_q <= !n0s_w[SUM_W-1] && (n0s_w != '0);
      un0_q     <= n0m_w[UD_W-1:0];
      n1_neg2_q <= !rz1_q[IN_W-1] && (rz1_q != '0);
      un1_q     <= UD_W'(rzm_w) << TRIG_FRAC;
      t_neg2_q  <= t_w[SUM_W-1];
      tm2_q     <= tm_w[TM_W-1:0];
      a2_q      <= a_w[SUM_W-1] ? -$signed(ash_w) : $signed(ash_w);
      pz2_q     <= pz1_q;
    end
  end

  // Stage 3: integer part test and divider seed
  logic [NUM_W-1:0] n0_w, n1_w, top0_w, top1_w;
  logic             ovf0_w, ovf1_w;

  assign n0_w   = {un0_q, {FRAC_BITS{1'b0}}};
  assign n1_w   = {un1_q, {FRAC_BITS{1'b0}}};
  assign top0_w = n0_w >> QW;
  assign top1_w = n1_w >> QW;
  assign ovf0_w = top0_w >= NUM_W'(ud2_q);
  assign ovf1_w = top1_w >= NUM_W'(ud2_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_o <= '0;
    end else if (en_i) begin
      tok_o.vld    <= vld2_q;
      tok_o.par    <= par2_q;
      tok_o.c_neg  <= c_neg2_q;
      tok_o.n0_neg <= n0_neg2_q;
      tok_o.n1_neg <= n1_neg2_q;
      tok_o.ud     <= ud2_q;
      tok_o.r0     <= ovf0_w ? '0 : top0_w[UD_W-1:0];
      tok_o.r1     <= ovf1_w ? '0 : top1_w[UD_W-1:0];
      tok_o.lo0    <= n0_w[QW-1:0];
      tok_o.lo1    <= n1_w[QW-1:0];
      tok_o.q0     <= '0;
      tok_o.q1     <= '0;
      tok_o.ovf0   <= ovf0_w;
      tok_o.ovf1   <= ovf1_w;
      tok_o.t_neg  <= t_neg2_q;
      tok_o.t_mag  <= tm2_q;
      tok_o.a      <= a2_q;
      tok_o.pz     <= pz2_q;
    end
  end

endmodule

// ----- src/l2pc_div_cell.sv -----
module l2pc_div_cell import l2pc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  l2pc_tok_t tok_i,
  output l2pc_tok_t tok_o
);

  // One restoring step on each lane: bring down a dividend bit, subtract if it fits
  logic [UD_W:0] pr0_w, pr1_w;
  logic          ge0_w, ge1_w;
  l2pc_tok_t     tok_d;

  assign pr0_w = {tok_i.r0, tok_i.lo0[QW-1]};
  assign pr1_w = {tok_i.r1, tok_i.lo1[QW-1]};
  assign ge0_w = pr0_w >= {1'b0, tok_i.ud};
  assign ge1_w = pr1_w >= {1'b0, tok_i.ud};

  always_comb begin
    tok_d     = tok_i;
    tok_d.r0  = ge0_w ? UD_W'(pr0_w - {1'b0, tok_i.ud}) : pr0_w[UD_W-1:0];
    tok_d.r1  = ge1_w ? UD_W'(pr1_w - {1'b0, tok_i.ud}) : pr1_w[UD_W-1:0];
    tok_d.lo0 = tok_i.lo0 << 1;
    tok_d.lo1 = tok_i.lo1 << 1;
    tok_d.q0  = {tok_i.q0[QW-2:0], ge0_w};
    tok_d.q1  = {tok_i.q1[QW-2:0], ge1_w};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_o <= '0;
    end else if (en_i) begin
      tok_o <= tok_d;
    end
  end

endmodule

// ----- src/l2pc_back.sv -----
module l2pc_back import l2pc_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  l2pc_tok_t                     tok_i,
  input  logic [LIM_W-1:0]              lim_tr_i,
  input  logic [LIM_W-1:0]              lim_ax_i,
  output logic                          vld_o,
  output logic [1:0]                    status_o,
  output logic signed [COORD_WIDTH-1:0] slope_tr_o,
  output logic signed [COORD_WIDTH-1:0] slope_ax_o,
  output logic signed [COORD_WIDTH-1:0] icpt_tr_o,
  output logic signed [COORD_WIDTH-1:0] icpt_ax_o
);

  // B1: limit tests
  logic       over0_w, over1_w;
  logic [1:0] st_w;

  assign over0_w = tok_i.ovf0 || (tok_i.q0 > lim_tr_i) ||
                   ((tok_i.q0 == lim_tr_i) && (tok_i.r0 != '0));
  assign over1_w = tok_i.ovf1 || (tok_i.q1 > lim_ax_i) ||
                   ((tok_i.q1 == lim_ax_i) && (tok_i.r1 != '0));

  always_comb begin
    if (tok_i.par) begin
      st_w = ST_PARALLEL;
    end else if (over0_w) begin
      st_w = ST_TRANS_OUT;
    end else if (over1_w) begin
      st_w = ST_AXIAL_OUT;
    end else begin
      st_w = ST_OK;
    end
  end

  logic                   vld1_q, vld2_q, vld3_q;
  logic [1:0]             st1_q, st2_q, st3_q;
  logic [QW-1:0]          q0_1_q, q1_1_q, q0_2_q, q1_2_q;
  logic                   s0_1_q, s1_1_q, s0_2_q, s1_2_q;
  logic                   tn1_q, tn2_q;
  logic [TM_W-1:0]        tm1_q;
  logic signed [A_W-1:0]  a1_q, a2_q, a3_q;
  logic signed [IN_W-1:0] pz1_q, pz2_q, pz3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
      vld_o  <= 1'b0;
    end else if (en_i) begin
      vld1_q <= tok_i.vld;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
      vld_o  <= vld3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st1_q  <= st_w;
      q0_1_q <= tok_i.q0;
      q1_1_q <= tok_i.q1;
      s0_1_q <= tok_i.n0_neg ^ tok_i.c_neg;
      s1_1_q <= tok_i.n1_neg ^ tok_i.c_neg;
      tn1_q  <= tok_i.t_neg;
      tm1_q  <= tok_i.t_mag;
      a1_q   <= tok_i.a;
      pz1_q  <= tok_i.pz;
    end
  end

  // B2: split multiplies, low and high slices of t
  logic [QW+TH_W-1:0]      pl0_q, pl1_q;
  logic [QW+TM_W-TH_W-1:0] ph0_q, ph1_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pl0_q  <= (QW+TH_W)'(q0_1_q) * (QW+TH_W)'(tm1_q[TH_W-1:0]);
      pl1_q  <= (QW+TH_W)'(q1_1_q) * (QW+TH_W)'(tm1_q[TH_W-1:0]);
      ph0_q  <= (QW+TM_W-TH_W)'(q0_1_q) * (QW+TM_W-TH_W)'(tm1_q[TM_W-1:TH_W]);
      ph1_q  <= (QW+TM_W-TH_W)'(q1_1_q) * (QW+TM_W-TH_W)'(tm1_q[TM_W-1:TH_W]);
      st2_q  <= st1_q;
      q0_2_q <= q0_1_q;
      q1_2_q <= q1_1_q;
      s0_2_q <= s0_1_q;
      s1_2_q <= s1_1_q;
      tn2_q  <= tn1_q;
      a2_q   <= a1_q;
      pz2_q  <= pz1_q;
    end
  end

  // B3: join partial products, truncate toward zero, apply signs
  logic [PM_W-1:0]          f0_w, f1_w;
  logic [PM_W-SH-1:0]       m0_w, m1_w;
  logic signed [SP_W-1:0]   sp0_q, sp1_q;
  logic signed [V_W-1:0]    v0_q, v1_q;

  assign f0_w = (PM_W'(ph0_q) << TH_W) + PM_W'(pl0_q);
  assign f1_w = (PM_W'(ph1_q) << TH_W) + PM_W'(pl1_q);
  assign m0_w = f0_w[PM_W-1:SH];
  assign m1_w = f1_w[PM_W-1:SH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sp0_q <= (s0_2_q ^ tn2_q) ? -$signed(SP_W'(m0_w)) : $signed(SP_W'(m0_w));
      sp1_q <= (s1_2_q ^ tn2_q) ? -$signed(SP_W'(m1_w)) : $signed(SP_W'(m1_w));
      v0_q  <= s0_2_q ? -$signed(V_W'(q0_2_q)) : $signed(V_W'(q0_2_q));
      v1_q  <= s1_2_q ? -$signed(V_W'(q1_2_q)) : $signed(V_W'(q1_2_q));
      st3_q <= st2_q;
      a3_q  <= a2_q;
      pz3_q <= pz2_q;
    end
  end

  // B4: intercepts, saturation, zero on rejection
  logic signed [U_W-1:0] u0_w, u1_w;
  logic                  ok_w;

  assign u0_w = U_W'(sp0_q) + U_W'(a3_q);
  assign u1_w = U_W'(sp1_q) + U_W'(pz3_q);
  assign ok_w = (st3_q == ST_OK);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      status_o   <= st3_q;
      slope_tr_o <= ok_w ? sat_coord(U_W'(v0_q)) : '0;
      slope_ax_o <= ok_w ? sat_coord(U_W'(v1_q)) : '0;
      icpt_tr_o  <= ok_w ? sat_coord(u0_w) : '0;
      icpt_ax_o  <= ok_w ? sat_coord(u1_w) : '0;
    end
  end

endmodule

// ----- src/lor_to_planogram_coords_unit.sv -----
// Stages: 3 front stages, 31 divider cells and 4 back stages lie between request
//   acceptance and result valid; the pipeline holds while the result side stalls.
// Throughput: one request per cycle; the whole pipeline advances together and
//   holds when the output register is full and not taken.
// Reset: asynchronous, active low; clears all valid flags and loads the register
//   defaults (unit cosine, zero sine, transaxial limit 1.0, axial limit 0).
module lor_to_planogram_coords_unit import l2pc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  l2pc_in_if.sink           in_req_i,
  l2pc_out_if.source        res_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  // Configuration registers
  logic signed [TRIG_W-1:0] cos_q, sin_q;
  logic [LIM_W-1:0]         lim_tr_q, lim_ax_q;
  logic [IDX_W-1:0]         idx_w;
  logic                     wr_w;

  assign pready = 1'b1;
  assign idx_w  = paddr[ADDR_W-1:2];
  assign wr_w   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cos_q    <= COS_RST;
      sin_q    <= SIN_RST;
      lim_tr_q <= MAX_TRANS_RST;
      lim_ax_q <= MAX_AXIAL_RST;
    end else if (wr_w) begin
      case (idx_w)
        REG_COS:       cos_q    <= pwdata[TRIG_W-1:0];
        REG_SIN:       sin_q    <= pwdata[TRIG_W-1:0];
        REG_MAX_TRANS: lim_tr_q <= pwdata[LIM_W-1:0];
        REG_MAX_AXIAL: lim_ax_q <= pwdata[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx_w)
      REG_COS:       prdata = 32'(unsigned'(cos_q));
      REG_SIN:       prdata = 32'(unsigned'(sin_q));
      REG_MAX_TRANS: prdata = 32'(lim_tr_q);
      REG_MAX_AXIAL: prdata = 32'(lim_ax_q);
      default:       prdata = '0;
    endcase
  end

  // Advance everything whenever the output register is free or being taken
  logic en_w;
  assign en_w           = !res_o.valid || res_o.ready;
  assign in_req_i.ready = en_w;

  // Rotation and divider seed
  l2pc_tok_t chain_w [QW+1];

  l2pc_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_w),
    .vld_i   (in_req_i.valid),
    .dir_x_i (in_req_i.dir_x),
    .dir_y_i (in_req_i.dir_y),
    .dir_z_i (in_req_i.dir_z),
    .pt_x_i  (in_req_i.pt_x),
    .pt_y_i  (in_req_i.pt_y),
    .pt_z_i  (in_req_i.pt_z),
    .cos_i   (cos_q),
    .sin_i   (sin_q),
    .tok_o   (chain_w[0])
  );

  // Row of divider cells, one quotient bit per lane each
  for (genvar i = 0; i < QW; i++) begin : g_cell
    l2pc_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en_w),
      .tok_i  (chain_w[i]),
      .tok_o  (chain_w[i+1])
    );
  end

  // Limit tests, intercept products, output register
  l2pc_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en_w),
    .tok_i      (chain_w[QW]),
    .lim_tr_i   (lim_tr_q),
    .lim_ax_i   (lim_ax_q),
    .vld_o      (res_o.valid),
    .status_o   (res_o.status),
    .slope_tr_o (res_o.slope_transaxial),
    .slope_ax_o (res_o.slope_axial),
    .icpt_tr_o  (res_o.icpt_transaxial),
    .icpt_ax_o  (res_o.icpt_axial)
  );

endmodule

// ----- src/l2pc_checker.sv -----
module l2pc_checker import l2pc_pkg::*; (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [1:0]                    status,
  input logic signed [COORD_WIDTH-1:0] slope_tr,
  input logic signed [COORD_WIDTH-1:0] slope_ax,
  input logic signed [COORD_WIDTH-1:0] icpt_tr,
  input logic signed [COORD_WIDTH-1:0] icpt_ax
);

  // An empty output register never blocks requests
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // Rejected lines carry zero coordinates
  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && (status != ST_OK) |->
      (slope_tr == '0) && (slope_ax == '0) && (icpt_tr == '0) && (icpt_ax == '0))
    else $error("rejected line with nonzero coordinates");

  // A stalled result stays valid, with status and transaxial slope and intercept stable
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> $stable(status) && $stable(slope_tr) && $stable(icpt_tr))
    else $error("result changed while stalled");

endmodule

bind lor_to_planogram_coords_unit l2pc_checker u_chk (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_ready  (in_req_i.ready),
  .out_valid (res_o.valid),
  .out_ready (res_o.ready),
  .status    (res_o.status),
  .slope_tr  (res_o.slope_transaxial),
  .slope_ax  (res_o.slope_axial),
  .icpt_tr   (res_o.icpt_transaxial),
  .icpt_ax   (res_o.icpt_axial)
);

// ----- tb/lor_to_planogram_coords_unit_tb.sv -----
`timescale 1ns / 1ps

module lor_to_planogram_coords_unit_tb;
  import l2pc_pkg::*;

  // One line of response as it enters the block
  typedef struct {
    logic signed [IN_W-1:0] dir_x;
    logic signed [IN_W-1:0] dir_y;
    logic signed [IN_W-1:0] dir_z;
    logic signed [IN_W-1:0] pt_x;
    logic signed [IN_W-1:0] pt_y;
    logic signed [IN_W-1:0] pt_z;
  } lor_t;

  // Planogram coordinates as they leave the block
  typedef struct {
    logic [1:0]                    status;
    logic signed [COORD_WIDTH-1:0] slope_transaxial;
    logic signed [COORD_WIDTH-1:0] slope_axial;
    logic signed [COORD_WIDTH-1:0] icpt_transaxial;
    logic signed [COORD_WIDTH-1:0] icpt_axial;
  } coords_t;

  // Holds its own copy of the panel registers and the queue of coordinates still
  // owed by the block, oldest first.
  class planogram_checker;
    longint          cos_q;
    longint          sin_q;
    longint unsigned lim_trans;
    longint unsigned lim_axial;
    coords_t         owed[$];
    int              errors;

    function new();
      cos_q     = 16384;
      sin_q     = 0;
      lim_trans = 65536;
      lim_axial = 0;
      errors    = 0;
    endfunction

    function void set_reg(input logic [IDX_W-1:0] idx, input logic [31:0] v);
      case (idx)
        REG_COS:       cos_q = longint'($signed(v[TRIG_W-1:0]));
        REG_SIN:       sin_q = longint'($signed(v[TRIG_W-1:0]));
        REG_MAX_TRANS: lim_trans = longint'(v[LIM_W-1:0]);
        REG_MAX_AXIAL: lim_axial = longint'(v[LIM_W-1:0]);
        default: ;
      endcase
    endfunction

    // Magnitude of num/den with FRAC_BITS fraction bits, truncated; huge marks a
    // quotient far beyond any limit, sticky a nonzero remainder.
    function void divide_q(input longint num, input longint den,
                           output longint unsigned mag, output bit huge, output bit sticky);
      longint unsigned un, ud, q0, r, f;
      un = (num < 0) ? longint'(-num) : num;
      ud = (den < 0) ? longint'(-den) : den;
      q0 = un / ud;
      r  = un % ud;
      f  = 0;
      mag = 0; huge = 0; sticky = 0;
      if (q0 >= (64'd1 << (62 - FRAC_BITS))) begin
        huge = 1;
        return;
      end
      for (int i = 0; i < FRAC_BITS; i++) begin
        r = r << 1;
        f = f << 1;
        if (r >= ud) begin
          r = r - ud;
          f = f | 1;
        end
      end
      mag    = (q0 << FRAC_BITS) | f;
      sticky = (r != 0);
    endfunction

    // (a*b) scaled down by both fraction widths, truncated toward zero
    function longint scaled_product(input longint a, input longint b);
      logic [127:0]    p;
      longint unsigned x, y, m;
      x = (a < 0) ? longint'(-a) : a;
      y = (b < 0) ? longint'(-b) : b;
      p = {64'd0, x} * {64'd0, y};
      m = p[FRAC_BITS+TRIG_FRAC +: 64];
      return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
    endfunction

    function logic signed [COORD_WIDTH-1:0] clip(input longint v);
      longint hi, lo;
      hi = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) v = hi;
      if (v < lo) v = lo;
      return v[COORD_WIDTH-1:0];
    endfunction

    function bit beyond(input longint unsigned mag, input bit huge, input bit sticky,
                        input longint unsigned lim);
      return huge || mag > lim || (mag == lim && sticky);
    endfunction

    function coords_t map_lor(input lor_t r);
      coords_t         res;
      longint          rx, ry, rz, px, py, pz, c, n0, n1, t, a, v0, v1;
      longint unsigned m0, m1;
      bit              h0, h1, s0, s1;
      res = '{ST_OK, 0, 0, 0, 0};
      rx = r.dir_x; ry = r.dir_y; rz = r.dir_z;
      px = r.pt_x;  py = r.pt_y;  pz = r.pt_z;
      c = cos_q * ry - sin_q * rx;
      if (c == 0) begin
        res.status = ST_PARALLEL;
        return res;
      end
      n0 = -(cos_q * rx + sin_q * ry);
      divide_q(n0, c, m0, h0, s0);
      if (beyond(m0, h0, s0, lim_trans)) begin
        res.status = ST_TRANS_OUT;
        return res;
      end
      n1 = -(rz * (longint'(1) <<< TRIG_FRAC));
      divide_q(n1, c, m1, h1, s1);
      if (beyond(m1, h1, s1, lim_axial)) begin
        res.status = ST_AXIAL_OUT;
        return res;
      end
      v0 = ((n0 < 0) != (c < 0)) ? -longint'(m0) : longint'(m0);
      v1 = ((n1 < 0) != (c < 0)) ? -longint'(m1) : longint'(m1);
      t  = cos_q * py - sin_q * px;
      a  = cos_q * px + sin_q * py;
      // truncate toward zero, not toward minus infinity
      a  = (a < 0) ? -((-a) >>> TRIG_FRAC) : (a >>> TRIG_FRAC);
      res.slope_transaxial = clip(v0);
      res.slope_axial      = clip(v1);
      res.icpt_transaxial  = clip(a + scaled_product(v0, t));
      res.icpt_axial       = clip(pz + scaled_product(v1, t));
      return res;
    endfunction

    function void note_request(input lor_t r);
      owed.push_back(map_lor(r));
    endfunction

    function void check_result(input coords_t got);
      coords_t exp_c;
      if (owed.size() == 0) begin
        $error("result arrived with nothing owed: status %0d", got.status);
        errors++;
        return;
      end
      exp_c = owed.pop_front();
      if (got.status !== exp_c.status) begin
        $error("status: expected %0d, got %0d", exp_c.status, got.status);
        errors++;
      end
      if (got.slope_transaxial !== exp_c.slope_transaxial) begin
        $error("slope_transaxial: expected %0d, got %0d",
               exp_c.slope_transaxial, got.slope_transaxial);
        errors++;
      end
      if (got.slope_axial !== exp_c.slope_axial) begin
        $error("slope_axial: expected %0d, got %0d", exp_c.slope_axial, got.slope_axial);
        errors++;
      end
      if (got.icpt_transaxial !== exp_c.icpt_transaxial) begin
        $error("icpt_transaxial: expected %0d, got %0d",
               exp_c.icpt_transaxial, got.icpt_transaxial);
        errors++;
      end
      if (got.icpt_axial !== exp_c.icpt_axial) begin
        $error("icpt_axial: expected %0d, got %0d", exp_c.icpt_axial, got.icpt_axial);
        errors++;
      end
    endfunction
  endclass

  localparam int LATENCY      = 38;
  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 20000;
  localparam int PHASE_ITEMS  = 300;
  localparam int TOTAL_ITEMS  = 6 * PHASE_ITEMS;

  logic              clk;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  l2pc_in_if  in_req ();
  l2pc_out_if res ();

  lor_to_planogram_coords_unit dut (
    .clk_i    (clk),
    .rst_ni   (rst_ni),
    .in_req_i (in_req),
    .res_o    (res),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  planogram_checker chk = new();

  int send_idle_pct;   // chance in a hundred that the sender skips a cycle
  int recv_idle_pct;   // chance in a hundred that the receiver drops ready
  bit hold_off;        // ask the receiver for one long stall
  int sent;
  int quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Record every accepted request and check every accepted result at the edge.
  always @(posedge clk) begin
    coords_t got;
    lor_t    req;
    if (rst_ni && in_req.valid && in_req.ready) begin
      req = '{in_req.dir_x, in_req.dir_y, in_req.dir_z, in_req.pt_x, in_req.pt_y, in_req.pt_z};
      chk.note_request(req);
    end
    if (rst_ni && res.valid && res.ready) begin
      got = '{res.status, res.slope_transaxial, res.slope_axial, res.icpt_transaxial,
              res.icpt_axial};
      chk.check_result(got);
    end
  end

  // Watchdog: end the run once nothing has moved for far too long.
  always @(posedge clk) begin
    if (!rst_ni || (in_req.valid && in_req.ready) || (res.valid && res.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: drop ready at random, and once hold it low for a long stretch so the
  // pipeline fills and back-pressures the request side.
  initial begin
    res.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk);
      if (hold_off) begin
        hold_off = 1'b0;
        res.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      res.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Idling pattern follows how far through the stimulus we are.
  always @(sent) begin
    if (sent < TOTAL_ITEMS / 3) begin
      send_idle_pct = 19;
      recv_idle_pct = 45;
    end else if (sent < 2 * TOTAL_ITEMS / 3) begin
      send_idle_pct = 45;
      recv_idle_pct = 19;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  end

  // Called at a falling edge; returns at a falling edge with valid still high.
  task automatic send_lor(input lor_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_req.valid <= 1'b0;
      @(negedge clk);
    end
    in_req.valid <= 1'b1;
    in_req.dir_x <= r.dir_x;
    in_req.dir_y <= r.dir_y;
    in_req.dir_z <= r.dir_z;
    in_req.pt_x  <= r.pt_x;
    in_req.pt_y  <= r.pt_y;
    in_req.pt_z  <= r.pt_z;
    @(posedge clk iff in_req.ready);
    @(negedge clk);
    sent++;
  endtask

  task automatic send_dir_pt(input int dx, input int dy, input int dz,
                             input int px, input int py, input int pz);
    lor_t r;
    r = '{dx, dy, dz, px, py, pz};
    send_lor(r);
  endtask

  // APB write: setup cycle, then access cycle; the register takes it at the edge.
  // Drop psel after the access and let the bus idle before the next transfer.
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= v;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk iff pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    chk.set_reg(idx, v);
    @(negedge clk);
  endtask

  // Let the pipeline drain before touching the panel registers.
  task automatic drain();
    in_req.valid <= 1'b0;
    while (chk.owed.size() != 0) @(negedge clk);
    repeat (LATENCY + 8) @(negedge clk);
  endtask

  task automatic set_panel(input logic [31:0] c, input logic [31:0] s,
                           input logic [31:0] lt, input logic [31:0] la);
    drain();
    write_reg(REG_COS, c);
    write_reg(REG_SIN, s);
    write_reg(REG_MAX_TRANS, lt);
    write_reg(REG_MAX_AXIAL, la);
  endtask

  function automatic logic signed [IN_W-1:0] rand_coord();
    case ($urandom_range(9))
      0, 1:    return $urandom;
      2, 3, 4: return int'($urandom_range(262143)) - 131072;
      5:       return 0;
      6: begin
        case ($urandom_range(3))
          0: return 32'sh7fffffff;
          1: return 32'sh80000000;
          2: return 1;
          default: return -1;
        endcase
      end
      default: return int'($urandom_range(33554431)) - 16777216;
    endcase
  endfunction

  task automatic send_random(input int n);
    lor_t r;
    for (int i = 0; i < n; i++) begin
      r = '{rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
            rand_coord()};
      // keep most lines well away from the panel plane so many get accepted
      if ($urandom_range(3) != 0 && r.dir_y == 0) r.dir_y = 32'sh00010000;
      send_lor(r);
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    hold_off      = 1'b0;
    sent          = 0;
    send_idle_pct = 19;
    recv_idle_pct = 45;
    in_req.valid  = 1'b0;
    in_req.dir_x  = '0;
    in_req.dir_y  = '0;
    in_req.dir_z  = '0;
    in_req.pt_x   = '0;
    in_req.pt_y   = '0;
    in_req.pt_z   = '0;
    repeat (10) @(negedge clk);
    rst_ni = 1'b1;
    @(negedge clk);

    // Directed, reset panel: unit cosine, transaxial limit 1.0, axial limit 0.
    send_dir_pt(0, 0, 0, 5, 6, 7);                            // zero direction: parallel
    send_dir_pt(32'sh00010000, 0, 32'sh00010000, 1, 2, 3);    // in panel plane: parallel
    send_dir_pt(0, 32'sh00010000, 0, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
    send_dir_pt(32'sh00010000, 32'sh00010000, 0, 100, 200, 300);  // slope at the limit
    send_dir_pt(32'sh00010001, 32'sh00010000, 0, 100, 200, 300);  // just over the limit
    send_dir_pt(0, 3, 1, 0, 0, 0);                            // axial nonzero, limit 0
    send_dir_pt(32'sh80000000, 32'sh7fffffff, 32'sh80000000, -1, -1, -1);
    send_dir_pt(1, 32'sh80000000, 0, 32'sh80000000, 32'sh7fffffff, 32'sh80000000);

    // Wide limits, upper register bits set to show they are ignored.
    set_panel(32'habcd_4000, 32'h1234_0000, 32'hffff_ffff, 32'h7fff_ffff);
    send_dir_pt(32'sh80000000, 1, 0, 0, 0, 0);                // huge slope: transaxial out
    send_dir_pt(0, 1, 32'sh7fffffff, 0, 0, 0);                // huge slope: axial out
    send_dir_pt(-32'sh7fff0000, 32'sh00010000, 0, 32'sh7fffffff, 32'sh7fffffff, 0);
    send_dir_pt(32'sh7fff0000, 32'sh00010000, 32'sh7fff0000,
                32'sh80000000, 32'sh7fffffff, 32'sh80000000); // intercepts saturate
    send_dir_pt(0, -32'sh00010000, 32'sh00030000, 32'sh7fffffff, -32'sh7fffffff,
                32'sh7fffffff);
    send_random(PHASE_ITEMS - 13);

    // Forty-five degrees; the receiver stalls long once in this phase.
    set_panel(32'd11585, 32'd11585, 32'h7fff_ffff, 32'h7fff_ffff);
    hold_off = 1'b1;
    send_random(PHASE_ITEMS);

    set_panel(32'd0, 32'hffff_c000, 32'd262144, 32'd131072);
    send_random(PHASE_ITEMS);

    // Both limits zero: only lines with no slope at all get through.
    set_panel(32'h0000_c000, 32'd16384, 32'd0, 32'd0);
    send_random(PHASE_ITEMS / 2);
    for (int i = 0; i < PHASE_ITEMS / 2; i++) begin
      send_dir_pt(32'sh00010000, 32'sh00010000, 0, rand_coord(), rand_coord(), rand_coord());
    end

    // Angle outside -1..1, used as given.
    set_panel(32'h0000_8000, 32'h0000_7fff, 32'h7fff_ffff, 32'h0001_0000);
    send_random(PHASE_ITEMS);

    set_panel(32'd9000, 32'hffff_cd38, 32'h7fff_ffff, 32'h7fff_ffff);
    send_random(PHASE_ITEMS);

    drain();
    if (chk.errors == 0 && chk.owed.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
